// ===== src/sar_pkg.sv =====
// sar_pkg: shared types and constants for the scaled aspect ratio block
// no dependencies; imported by scaled_aspect_ratio and its checker
package sar_pkg;

  localparam int unsigned CFG_ADDR_W = 4;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned DIM_W      = 13;
  localparam int unsigned ASPECT_W   = 30;

  typedef enum logic [1:0] {
    REG_WIDESCREEN     = 2'd0,
    REG_DISPLAY_WIDTH  = 2'd1,
    REG_DISPLAY_HEIGHT = 2'd2
  } cfg_reg_e;

  localparam logic             RST_WIDESCREEN     = 1'b1;
  localparam logic [DIM_W-1:0] RST_DISPLAY_WIDTH  = 13'd1280;
  localparam logic [DIM_W-1:0] RST_DISPLAY_HEIGHT = 13'd720;

  localparam logic [4:0] ASPECT_WIDE_X   = 5'd16;
  localparam logic [4:0] ASPECT_WIDE_Y   = 5'd9;
  localparam logic [4:0] ASPECT_NARROW_X = 5'd4;
  localparam logic [4:0] ASPECT_NARROW_Y = 5'd3;

endpackage

// ===== src/scaled_aspect_ratio.sv =====
// scaled_aspect_ratio: reduces a frame size against the display resolution
// and returns the reduced display aspect; depends on sar_pkg
//
//   channel | direction | handshake                 | payload
//   in      | sink      | in_valid_i / in_stall_o   | frame_width_i, frame_height_i
//   out     | source    | out_valid_o / out_stall_i | aspect_horizontal_o,
//           |           |                           | aspect_vertical_o, zero_error_o
//   cfg     | sink      | psel, penable, pwrite     | paddr, pwdata, prdata
//
// one beat runs three binary gcd runs on the shared subtractor (one step a cycle,
// then a shift back by the common factors of two) and six restoring divisions
// with 2*DIMENSION_BITS+4-bit quotients on the same subtractor;
// the last two divisions are skipped when both products are zero
// in_stall_o is high from acceptance until the result reaches the output register
// the result register waits on out_stall_i; a new beat is taken meanwhile
// reset clears the sequencer and loads the register reset values
module scaled_aspect_ratio
  import sar_pkg::*;
#(
  parameter int unsigned DIMENSION_BITS = 13
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [DIM_W-1:0]      frame_width_i,
  input  logic [DIM_W-1:0]      frame_height_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [ASPECT_W-1:0]   aspect_horizontal_o,
  output logic [ASPECT_W-1:0]   aspect_vertical_o,
  output logic                  zero_error_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int unsigned DB = DIMENSION_BITS;
  localparam int unsigned W  = 2 * DB + 4;
  localparam int unsigned KW = $clog2(W);
  localparam int unsigned CW = $clog2(W + 1);
  localparam logic [DIM_W-1:0] DIM_MAX = DIM_W'((1 << DB) - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_GCD,
    ST_SHIFT,
    ST_DIV,
    ST_MUL,
    ST_OUT
  } state_e;

  typedef enum logic [3:0] {
    STEP_GCD_W,
    STEP_DIV_FW,
    STEP_DIV_DW,
    STEP_GCD_H,
    STEP_DIV_FH,
    STEP_DIV_DH,
    STEP_MUL,
    STEP_GCD_HV,
    STEP_DIV_H,
    STEP_DIV_V,
    STEP_OUT
  } step_e;

  function automatic logic [DB-1:0] sat_dim(logic [DIM_W-1:0] v);
    logic [DB-1:0] r;
    if (v > DIM_MAX) begin
      r = DIM_MAX[DB-1:0];
    end else begin
      r = v[DB-1:0];
    end
    return r;
  endfunction

  // configuration registers
  logic             widescreen_q;
  logic [DIM_W-1:0] display_width_q;
  logic [DIM_W-1:0] display_height_q;
  logic             cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      widescreen_q     <= RST_WIDESCREEN;
      display_width_q  <= RST_DISPLAY_WIDTH;
      display_height_q <= RST_DISPLAY_HEIGHT;
    end else if (cfg_write) begin
      if (paddr[3:2] == REG_WIDESCREEN) begin
        widescreen_q <= pwdata[0];
      end else if (paddr[3:2] == REG_DISPLAY_WIDTH) begin
        display_width_q <= pwdata[DIM_W-1:0];
      end else if (paddr[3:2] == REG_DISPLAY_HEIGHT) begin
        display_height_q <= pwdata[DIM_W-1:0];
      end
    end
  end

  always_comb begin
    case (cfg_reg_e'(paddr[3:2]))
      REG_WIDESCREEN:     prdata = CFG_DATA_W'(widescreen_q);
      REG_DISPLAY_WIDTH:  prdata = CFG_DATA_W'(display_width_q);
      REG_DISPLAY_HEIGHT: prdata = CFG_DATA_W'(display_height_q);
      default:            prdata = '0;
    endcase
  end

  // sequencer and datapath
  state_e            state_q;
  step_e             step_q;
  logic [DB-1:0]     fw_q, fh_q, dw_q, dh_q;
  logic [W-1:0]      h_q, v_q, g_q;
  logic [W-1:0]      ua_q, ub_q, rem_q;
  logic [KW-1:0]     k_q;
  logic [CW-1:0]     cnt_q;
  logic              out_valid_q;
  logic [ASPECT_W-1:0] out_h_q, out_v_q;
  logic              out_err_q;

  // shared subtractor
  logic [W:0]        sub_x, sub_y;
  logic [W+1:0]      diff, neg_diff;
  logic              borrow;
  logic [W-1:0]      quo_next, rem_next;

  always_comb begin
    if (state_q == ST_DIV) begin
      sub_x = {rem_q, ua_q[W-1]};
      sub_y = {1'b0, g_q};
    end else begin
      sub_x = {1'b0, ua_q};
      sub_y = {1'b0, ub_q};
    end
  end

  assign diff     = {1'b0, sub_x} - {1'b0, sub_y};
  assign neg_diff = ~diff + {{(W+1){1'b0}}, 1'b1};
  assign borrow   = diff[W+1];
  assign quo_next = {ua_q[W-2:0], ~borrow};
  assign rem_next = borrow ? sub_x[W-1:0] : diff[W-1:0];

  // shared multiplier
  logic [DB-1:0]   mul_a, mul_b;
  logic [2*DB-1:0] prod;

  assign mul_a = (cnt_q == CW'(2)) ? fw_q : fh_q;
  assign mul_b = (cnt_q == CW'(2)) ? dh_q : dw_q;
  assign prod  = mul_a * mul_b;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= STEP_GCD_W;
      fw_q        <= '0;
      fh_q        <= '0;
      dw_q        <= '0;
      dh_q        <= '0;
      h_q         <= '0;
      v_q         <= '0;
      g_q         <= '0;
      ua_q        <= '0;
      ub_q        <= '0;
      rem_q       <= '0;
      k_q         <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      out_h_q     <= '0;
      out_v_q     <= '0;
      out_err_q   <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i && state_q != ST_OUT) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            fw_q    <= sat_dim(frame_width_i);
            fh_q    <= sat_dim(frame_height_i);
            dw_q    <= sat_dim(display_width_q);
            dh_q    <= sat_dim(display_height_q);
            step_q  <= STEP_GCD_W;
            state_q <= ST_LOAD;
          end
        end
        ST_LOAD: begin
          rem_q <= '0;
          k_q   <= '0;
          cnt_q <= CW'(W);
          case (step_q)
            STEP_GCD_W: begin
              ua_q    <= W'(fw_q);
              ub_q    <= W'(dw_q);
              state_q <= ST_GCD;
            end
            STEP_DIV_FW: begin
              ua_q    <= W'(fw_q);
              state_q <= ST_DIV;
            end
            STEP_DIV_DW: begin
              ua_q    <= W'(dw_q);
              state_q <= ST_DIV;
            end
            STEP_GCD_H: begin
              ua_q    <= W'(fh_q);
              ub_q    <= W'(dh_q);
              state_q <= ST_GCD;
            end
            STEP_DIV_FH: begin
              ua_q    <= W'(fh_q);
              state_q <= ST_DIV;
            end
            STEP_DIV_DH: begin
              ua_q    <= W'(dh_q);
              state_q <= ST_DIV;
            end
            STEP_MUL: begin
              cnt_q   <= CW'(2);
              state_q <= ST_MUL;
            end
            STEP_GCD_HV: begin
              ua_q    <= h_q;
              ub_q    <= v_q;
              state_q <= ST_GCD;
            end
            STEP_DIV_H: begin
              ua_q    <= h_q;
              state_q <= ST_DIV;
            end
            STEP_DIV_V: begin
              ua_q    <= v_q;
              state_q <= ST_DIV;
            end
            STEP_OUT: begin
              state_q <= ST_OUT;
            end
            default: begin
              state_q <= ST_IDLE;
            end
          endcase
        end
        ST_GCD: begin
          if (ua_q == '0) begin
            g_q     <= ub_q;
            state_q <= ST_SHIFT;
          end else if (ub_q == '0) begin
            g_q     <= ua_q;
            state_q <= ST_SHIFT;
          end else if (!ua_q[0] && !ub_q[0]) begin
            ua_q <= ua_q >> 1;
            ub_q <= ub_q >> 1;
            k_q  <= k_q + 1'b1;
          end else if (!ua_q[0]) begin
            ua_q <= ua_q >> 1;
          end else if (!ub_q[0]) begin
            ub_q <= ub_q >> 1;
          end else if (!borrow) begin
            ua_q <= {1'b0, diff[W-1:1]};
          end else begin
            ub_q <= {1'b0, neg_diff[W-1:1]};
          end
        end
        ST_SHIFT: begin
          if (k_q == '0) begin
            state_q <= ST_LOAD;
            if (step_q == STEP_GCD_HV && g_q == '0) begin
              // both products zero, h and v already read 0:0
              step_q <= STEP_OUT;
            end else begin
              if (g_q == '0) begin
                g_q <= {{(W-1){1'b0}}, 1'b1};
              end
              step_q <= step_e'(step_q + 1'b1);
            end
          end else begin
            g_q <= g_q << 1;
            k_q <= k_q - 1'b1;
          end
        end
        ST_DIV: begin
          ua_q  <= quo_next;
          rem_q <= rem_next;
          cnt_q <= cnt_q - 1'b1;
          if (cnt_q == CW'(1)) begin
            case (step_q)
              STEP_DIV_FW: fw_q <= quo_next[DB-1:0];
              STEP_DIV_DW: dw_q <= quo_next[DB-1:0];
              STEP_DIV_FH: fh_q <= quo_next[DB-1:0];
              STEP_DIV_DH: dh_q <= quo_next[DB-1:0];
              STEP_DIV_H:  h_q  <= quo_next;
              STEP_DIV_V:  v_q  <= quo_next;
              default:     h_q  <= h_q;
            endcase
            step_q  <= step_e'(step_q + 1'b1);
            state_q <= ST_LOAD;
          end
        end
        ST_MUL: begin
          cnt_q <= cnt_q - 1'b1;
          if (cnt_q == CW'(2)) begin
            h_q <= W'(prod);
          end else if (cnt_q == CW'(1)) begin
            v_q <= W'(prod);
          end else begin
            h_q     <= widescreen_q ? h_q * ASPECT_WIDE_X : h_q * ASPECT_NARROW_X;
            v_q     <= widescreen_q ? v_q * ASPECT_WIDE_Y : v_q * ASPECT_NARROW_Y;
            step_q  <= step_e'(step_q + 1'b1);
            state_q <= ST_LOAD;
          end
        end
        ST_OUT: begin
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q <= 1'b1;
            out_h_q     <= ASPECT_W'(h_q);
            out_v_q     <= ASPECT_W'(v_q);
            out_err_q   <= (h_q == '0) && (v_q == '0);
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_stall_o          = (state_q != ST_IDLE);
  assign out_valid_o         = out_valid_q;
  assign aspect_horizontal_o = out_h_q;
  assign aspect_vertical_o   = out_v_q;
  assign zero_error_o        = out_err_q;

endmodule

// ===== src/sar_checker.sv =====
// sar_checker: port-level assertions for scaled_aspect_ratio, bound to the top
// depends on sar_pkg
module sar_checker
  import sar_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input logic [ASPECT_W-1:0] aspect_horizontal_o,
  input logic [ASPECT_W-1:0] aspect_vertical_o,
  input logic                zero_error_o
);

  // busy right after taking a beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("block took a beat without going busy");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(aspect_horizontal_o)
      && $stable(aspect_vertical_o) && $stable(zero_error_o))
    else $error("stalled result beat changed");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && zero_error_o |-> aspect_horizontal_o == '0 && aspect_vertical_o == '0)
    else $error("error beat carries a nonzero ratio");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !zero_error_o |-> aspect_horizontal_o != '0 || aspect_vertical_o != '0)
    else $error("zero ratio without error flag");

endmodule

bind scaled_aspect_ratio sar_checker u_sar_checker (.*);
